// ===== rtl/core/grid_percolation_flood_fill_assert.svh =====
// assertion macros used by the flood fill controller rtl
// no dependencies
`ifndef GRID_PERCOLATION_FLOOD_FILL_ASSERT_SVH
`define GRID_PERCOLATION_FLOOD_FILL_ASSERT_SVH
// implication checked on every rising clock edge out of reset
`define GPF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define GPF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/gpf_pkg.sv =====
// types and constants for the percolation flood fill block
// no dependencies
`default_nettype none
package gpf_pkg;
  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int unsigned COUNT_W = 11;

  typedef struct packed {
    logic       operation;
    logic [4:0] row_index;
    logic [4:0] column_index;
  } gpf_in_t;

  typedef struct packed {
    logic               cell_open;
    logic               cell_full;
    logic [COUNT_W-1:0] open_cells;
    logic               percolates;
    logic               out_of_range;
  } gpf_out_t;
endpackage
`default_nettype wire

// ===== rtl/core/grid_percolation_flood_fill.sv =====
// flow: out-of-range requests skip the check; a query or an open of an open cell reads and
// checks the cell; an open that starts no fill also reads the four neighbors; an open
// that fills seeds the stack, pops each cell and rmws its neighbors, then re-reads the cell
// throughput: one transaction at a time, busy is high through the result strobe
// reset: synchronous rst_n; then a clearing sweep of every cell store address, busy high
// controller around the cell store and the fill stack; uses gpf_pkg; out_valid lasts one cycle
`default_nettype none
module grid_percolation_flood_fill import gpf_pkg::*; #(
  parameter int unsigned MAX_SIDE = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire gpf_in_t  in_data,
  output logic          out_valid,
  output gpf_out_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [5:0] cfg_wdata
);
  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
  localparam int unsigned DW = AW + 1;
  localparam logic [6:0] MAXS = 7'(MAX_SIDE);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_NRD  = 4'd4;
  localparam logic [3:0] S_NCHK = 4'd5;
  localparam logic [3:0] S_POP  = 4'd6;
  localparam logic [3:0] S_POPW = 4'd7;
  localparam logic [3:0] S_NBR  = 4'd8;
  localparam logic [3:0] S_NBW  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_FINW = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]  st_r, st_nxt;
  logic [5:0]  side_r;
  logic [6:0]  side;
  logic [AW-1:0] clr_r;
  logic        op_r;
  logic [6:0]  row_r, col_r;
  logic [6:0]  cr_r, cc_r;
  logic [1:0]  dir_r;
  logic        ready_r;
  logic [DW-1:0] depth_r;
  logic [COUNT_W-1:0] total_r;
  logic        bottom_r;
  logic        oor_r;
  logic        res_open_r, res_full_r;

  logic          cm_we;
  logic [AW-1:0] cm_waddr, cm_raddr;
  logic [1:0]    cm_wdata, cm_rdata;
  logic          sk_we;
  logic [AW-1:0] sk_waddr, sk_raddr, sk_rdata;

  assign side = (7'(side_r) > MAXS) ? MAXS : 7'(side_r);

  function automatic logic [AW-1:0] addr_of(input logic [6:0] r, input logic [6:0] c);
    addr_of = {r[CW-1:0], c[CW-1:0]};
  endfunction

  // neighbor under test in NRD/NBR: up, right, down, left
  logic [6:0] nr, nc;
  logic       n_in;
  always_comb begin
    nr = cr_r;
    nc = cc_r;
    n_in = 1'b1;
    unique case (dir_r)
      2'd0: begin nr = cr_r - 7'd1; n_in = (cr_r != 7'd0); end
      2'd1: nc = cc_r + 7'd1;
      2'd2: nr = cr_r + 7'd1;
      default: begin nc = cc_r - 7'd1; n_in = (cc_r != 7'd0); end
    endcase
    n_in = n_in && (nr < side) && (nc < side);
  end

  always_comb begin
    cm_we = 1'b0;
    cm_waddr = addr_of(cr_r, cc_r);
    cm_wdata = cm_rdata;
    cm_raddr = addr_of(cr_r, cc_r);
    sk_we = 1'b0;
    sk_waddr = depth_r[AW-1:0];
    sk_raddr = depth_r[AW-1:0] - AW'(1);
    unique case (st_r)
      S_CLR: begin cm_we = 1'b1; cm_waddr = clr_r; cm_wdata = 2'b00; end
      S_IDLE: cm_raddr = addr_of({2'b00, in_data.row_index}, {2'b00, in_data.column_index});
      S_CHK: if (!op_r && !cm_rdata[0]) begin cm_we = 1'b1; cm_wdata = {cm_rdata[1], 1'b1}; end
      S_NRD, S_NBR: cm_raddr = addr_of(nr, nc);
      S_FIN: begin
        // seed the fill: full bit set and pushed
        cm_we = 1'b1; cm_wdata = 2'b11;
        sk_we = 1'b1; sk_waddr = '0;
      end
      S_NBW: if (n_in && cm_rdata[0] && !cm_rdata[1]) begin
        cm_we = 1'b1; cm_waddr = addr_of(nr, nc); cm_wdata = 2'b11;
        sk_we = depth_r < DW'(CELLS);
      end
      default: ;
    endcase
  end

  logic [AW-1:0] sk_wdata;
  assign sk_wdata = (st_r == S_FIN) ? addr_of(cr_r, cc_r) : addr_of(nr, nc);

  gpf_cell_mem #(.AW(AW)) u_cells (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata)
  );
  gpf_stack_mem #(.AW(AW)) u_stack (
    .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      // every address of the store is swept, not only the cells of the largest grid
      S_CLR:  if (clr_r == '1) st_nxt = S_IDLE;
      S_IDLE: if (start) st_nxt = S_RD;
      S_RD:   st_nxt = oor_r ? S_DONE : S_CHK;
      S_CHK:  priority if (!op_r && !cm_rdata[0])
                st_nxt = (row_r == 7'd0) ? S_FIN : S_NRD;
              else st_nxt = S_DONE;
      S_NRD:  st_nxt = S_NCHK;
      S_NCHK: priority if (n_in && cm_rdata[1]) st_nxt = S_FIN;
              else if (dir_r == 2'd3) st_nxt = S_DONE;
              else st_nxt = S_NRD;
      S_FIN:  st_nxt = S_POP;
      S_POP:  st_nxt = (depth_r == '0) ? S_FINW : S_POPW;
      S_POPW: st_nxt = S_NBR;
      S_NBR:  st_nxt = S_NBW;
      S_NBW:  st_nxt = (dir_r == 2'd3) ? S_POP : S_NBR;
      S_FINW: st_nxt = S_RD;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      side_r <= 6'd32;
      total_r <= '0;
      bottom_r <= 1'b0;
      depth_r <= '0;
      dir_r <= '0;
      ready_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) side_r <= cfg_wdata;
      unique case (st_r)
        S_CLR: clr_r <= clr_r + AW'(1);
        S_IDLE: if (start) begin
          op_r <= in_data.operation;
          row_r <= {2'b00, in_data.row_index};
          col_r <= {2'b00, in_data.column_index};
          cr_r <= {2'b00, in_data.row_index};
          cc_r <= {2'b00, in_data.column_index};
          oor_r <= ({2'b00, in_data.row_index} >= side) ||
                   ({2'b00, in_data.column_index} >= side);
          ready_r <= 1'b0;
        end
        S_RD: ;
        S_CHK: begin
          res_open_r <= cm_rdata[0];
          res_full_r <= cm_rdata[1];
          dir_r <= '0;
          if (!op_r && !cm_rdata[0] && total_r != '1) total_r <= total_r + COUNT_W'(1);
        end
        S_NRD: ;
        S_NCHK: dir_r <= dir_r + 2'd1;
        S_FIN: begin
          depth_r <= DW'(1);
          ready_r <= 1'b1;
          if (cr_r == side - 7'd1) bottom_r <= 1'b1;
        end
        S_POP: if (depth_r != '0) depth_r <= depth_r - DW'(1);
        S_POPW: begin
          cr_r <= {{(7-CW){1'b0}}, sk_rdata[AW-1:CW]};
          cc_r <= {{(7-CW){1'b0}}, sk_rdata[CW-1:0]};
          dir_r <= '0;
        end
        S_NBR: ;
        S_NBW: begin
          dir_r <= dir_r + 2'd1;
          if (n_in && cm_rdata[0] && !cm_rdata[1]) begin
            if (depth_r < DW'(CELLS)) depth_r <= depth_r + DW'(1);
            if (nr == side - 7'd1) bottom_r <= 1'b1;
          end
        end
        S_FINW: begin cr_r <= row_r; cc_r <= col_r; op_r <= OP_QUERY; end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  always_comb begin
    out_data.cell_open = oor_r ? 1'b0 : res_open_r | (op_r == OP_OPEN);
    out_data.cell_full = oor_r ? 1'b0 : res_full_r | ready_r;
    out_data.open_cells = total_r;
    out_data.percolates = bottom_r;
    out_data.out_of_range = oor_r;
  end

  `include "grid_percolation_flood_fill_assert.svh"
  `GPF_ASSERT_IMP(a_no_start_busy, out_valid, busy)
  `GPF_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  `GPF_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= DW'(CELLS))
  `GPF_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy)
endmodule
`default_nettype wire

// ===== rtl/core/gpf_cell_mem.sv =====
// cell store: open and full bits per cell, one write and one registered read port
// uses gpf_pkg; clearing is done by the controller sweep
`default_nettype none
module gpf_cell_mem import gpf_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [1:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [1:0]         rdata
);
  logic [1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/gpf_stack_mem.sv =====
// fill stack storage, one write and one registered read port
// no package dependency
`default_nettype none
module gpf_stack_mem #(
  parameter int unsigned AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [AW-1:0]      rdata
);
  logic [AW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== dv/grid_percolation_flood_fill_test.sv =====
// self-checking testbench for the percolation grid flood fill block
// depends on gpf_pkg and grid_percolation_flood_fill; predicts results with its own grid model
`default_nettype none
module grid_percolation_flood_fill_test import gpf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX = 32;
  localparam int NCELL = SIDE_MAX * SIDE_MAX;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  gpf_in_t in_data = '0;
  logic out_valid;
  gpf_out_t out_data;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;

  grid_percolation_flood_fill #(.MAX_SIDE(SIDE_MAX)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // grid model state
  bit open_cell[NCELL];
  bit full_cell[NCELL];
  bit [10:0] opened_count;
  bit bottom_hit;
  bit [5:0] side_reg;
  int fill_work[$];

  gpf_out_t pending_results[$];
  int mismatch_count = 0;
  int sent_count = 0;

  function automatic int active_side();
    return (side_reg > SIDE_MAX) ? SIDE_MAX : int'(side_reg);
  endfunction

  function automatic bit is_full_in(int r, int c, int s);
    return r >= 0 && c >= 0 && r < s && c < s && full_cell[r * SIDE_MAX + c];
  endfunction

  function automatic void mark_full(int r, int c, int s);
    int k;
    if (r < 0 || c < 0 || r >= s || c >= s) return;
    k = r * SIDE_MAX + c;
    if (full_cell[k] || !open_cell[k]) return;
    full_cell[k] = 1'b1;
    if (r == s - 1) bottom_hit = 1'b1;
    fill_work.push_back(k);
  endfunction

  function automatic gpf_out_t predict_cell(gpf_in_t t);
    gpf_out_t res;
    int s, r, c, k, pr, pc;
    bit ready;
    s = active_side();
    r = t.row_index;
    c = t.column_index;
    res = '0;
    if (r >= s || c >= s) begin
      res.open_cells = opened_count;
      res.percolates = bottom_hit;
      res.out_of_range = 1'b1;
      return res;
    end
    k = r * SIDE_MAX + c;
    if (t.operation == OP_OPEN && !open_cell[k]) begin
      open_cell[k] = 1'b1;
      if (opened_count != 11'h7ff) opened_count++;
      ready = (r == 0) || is_full_in(r - 1, c, s) || is_full_in(r, c + 1, s) ||
              is_full_in(r + 1, c, s) || is_full_in(r, c - 1, s);
      if (ready) begin
        fill_work.delete();
        mark_full(r, c, s);
        while (fill_work.size() > 0) begin
          k = fill_work.pop_back();
          pr = k / SIDE_MAX;
          pc = k % SIDE_MAX;
          mark_full(pr - 1, pc, s);
          mark_full(pr, pc + 1, s);
          mark_full(pr + 1, pc, s);
          mark_full(pr, pc - 1, s);
        end
      end
      k = r * SIDE_MAX + c;
    end
    res.cell_open = open_cell[k];
    res.cell_full = full_cell[k];
    res.open_cells = opened_count;
    res.percolates = bottom_hit;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    gpf_out_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data !== exp_res) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p actual %p", exp_res, out_data);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_cell(bit op, int r, int c, bit gaps = 1'b1);
    gpf_in_t t;
    if (gaps) idle_gap();
    t.operation = op;
    t.row_index = r[4:0];
    t.column_index = c[4:0];
    start <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_cell(t));
    sent_count++;
    start <= 1'b0;
    // the block stays busy here, so this edge costs no throughput
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_side(int s);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= s[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    side_reg = s[5:0];
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_cell(OP_QUERY, 0, 0);
    send_cell(OP_OPEN, 31, 31);
    send_cell(OP_OPEN, 0, 31);
    send_cell(OP_OPEN, 0, 31);
    send_cell(OP_OPEN, 1, 31);
    send_cell(OP_QUERY, 31, 31);
    write_side(0);
    send_cell(OP_OPEN, 0, 0);
    write_side(63);
    send_cell(OP_QUERY, 31, 0);
    write_side(1);
    send_cell(OP_OPEN, 0, 0);
    send_cell(OP_OPEN, 0, 1);
    send_cell(OP_QUERY, 1, 0);
    write_side(2);
    send_cell(OP_OPEN, 1, 1);
    send_cell(OP_QUERY, 1, 1);
  endtask

  // open a full column so the fill reaches the bottom
  task automatic test_column_percolates(int s);
    int col;
    write_side(s);
    col = $urandom_range(0, s - 1);
    for (int r = s - 1; r >= 0; r--) send_cell(OP_OPEN, r, col, 1'b0);
    send_cell(OP_QUERY, s - 1, col);
  endtask

  task automatic test_random(int s, int n);
    int r, c, lim;
    write_side(s);
    lim = (s > 32) ? 31 : s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 31);
        c = $urandom_range(0, 31);
      end else begin
        r = $urandom_range(0, lim - 1);
        c = $urandom_range(0, lim - 1);
      end
      send_cell($urandom_range(0, 3) == 0, r, c, $urandom_range(0, 2) == 0);
    end
  endtask

  initial begin
    side_reg = 6'd32;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_column_percolates(5);
    test_random(6, 60);
    test_random(3, 30);
    test_random(12, 100);
    test_column_percolates(20);
    test_random(32, 150);
    test_random(40, 60);
    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("grid_percolation_flood_fill verification clean");
    else
      $display("grid_percolation_flood_fill verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("grid_percolation_flood_fill verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/gpf_pkg.sv
rtl/core/gpf_cell_mem.sv
rtl/core/gpf_stack_mem.sv
rtl/core/grid_percolation_flood_fill.sv
dv/grid_percolation_flood_fill_test.sv
